// ===== rtl/lavm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types, constants and fixed-point helpers of the look-at view matrix
// core.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int DIR_FRAC_BITS    = 30;
  localparam int MIN_LEN_W        = 30;
  localparam int LAVM_QUEUE_DEPTH = 2;

  localparam logic [MIN_LEN_W-1:0] MINLEN_RESET = MIN_LEN_W'(1074);
  localparam logic signed [31:0]   ONE_DIR      = 32'sd1 <<< DIR_FRAC_BITS;
  localparam logic signed [31:0]   Q16_ONE      = 32'sd65536;
  localparam logic signed [67:0]   RND_HALF     = 68'sd1 <<< (DIR_FRAC_BITS - 1);

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] view_x;
    logic signed [31:0] view_y;
    logic signed [31:0] view_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lavm_in_t;

  typedef struct packed {
    logic [1:0]         column_index;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
    logic               degenerate;
    logic               is_last;
  } lavm_out_t;

  typedef logic [2:0][31:0] vec3_t;

  function automatic logic [31:0] pick3(input vec3_t v, input logic [1:0] idx);
    logic [31:0] r;
    case (idx)
      2'd1:    r = v[1];
      2'd2:    r = v[2];
      default: r = v[0];
    endcase
    return r;
  endfunction

  // Round to nearest (halves toward plus infinity) while dropping the
  // direction fraction bits.
  function automatic logic signed [67:0] rnd(input logic signed [67:0] x);
    logic signed [67:0] s;
    s = x + RND_HALF;
    return s >>> DIR_FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'sd2147483647) r = 32'sh7fffffff;
    else if (x < -68'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/lavm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_front
// Input side: takes items from the input channel into a short queue that
// the back end drains at its own pace.
// ----------------------------------------------------------------------------
module lavm_front import lavm_pkg::*; #(
  parameter int DEPTH = LAVM_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lavm_in_t in_data,
  output logic     q_valid,
  output lavm_in_t q_data,
  input  logic     q_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lavm_in_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push;

  assign in_stall = (count_r == CW'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= in_data;
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) count_r <= count_r + 1'b1;
      else if (!push && q_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== rtl/lavm_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_sqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module lavm_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] rad_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;

  assign rem_sh = {rem_r[32:0], rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign done   = done_r;
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[61:0], 2'b00};
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[30:0], ge};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/lavm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_div
// Rounded normalizing divide round(c * 2^F / len) on magnitudes, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lavm_div import lavm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] c,
  input  logic [31:0]        len,
  output logic               done,
  output logic signed [31:0] q
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] dlo_r;
  logic [31:0] len_r;
  logic [31:0] q_r;
  logic        neg_r;
  logic [31:0] mag;
  logic [63:0] dvd;
  logic [32:0] rem_sh;
  logic        ge;

  assign mag    = c[31] ? 32'(-c) : c;
  assign dvd    = ({32'b0, mag} << DIR_FRAC_BITS) + {33'b0, len[31:1]};
  assign rem_sh = {rem_r[31:0], dlo_r[31]};
  assign ge     = (rem_sh >= {1'b0, len_r});
  assign done   = done_r;
  assign q      = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        // The quotient fits in 32 bits since |c| <= len, so the upper half
        // of the dividend is already below len.
        rem_r  <= {1'b0, dvd[63:32]};
        dlo_r  <= dvd[31:0];
        len_r  <= len;
        neg_r  <= c[31];
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sh - {1'b0, len_r} : rem_sh;
        dlo_r <= {dlo_r[30:0], 1'b0};
        q_r   <= {q_r[30:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/lavm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavm_back
// Back end: a sequencer around one shared 32x32 multiplier, the square root
// and divide units, and the output register that sends four columns.
// ----------------------------------------------------------------------------
module lavm_back import lavm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lavm_in_t             q_data,
  output logic                 q_pop,
  input  logic [MIN_LEN_W-1:0] min_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lavm_out_t            out_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_SQRT, ST_CAND, ST_DIV, ST_RIGHT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_VLEN, OP_DOT, OP_ULEN, OP_T0, OP_T1, OP_T2
  } mac_op_t;

  state_t             state_r;
  mac_op_t            op_r;
  logic [2:0]         k_r;
  logic [1:0]         fb_r;
  logic [1:0]         cidx_r;
  logic [1:0]         col_r;
  logic               degen_r;
  vec3_t              eye_r, view_r, wup_r, up_r, right_r, tr_r;
  logic signed [31:0] s_r;
  logic [31:0]        len_r;
  logic signed [63:0] prod_r;
  logic signed [67:0] acc_r;
  logic               out_valid_r;
  lavm_out_t          out_data_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [67:0] prod_x;
  logic signed [67:0] acc_sum;
  logic signed [31:0] base_c;
  logic signed [31:0] cand_val;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;
  logic               len_ok;
  logic               div_start, div_done;
  logic signed [31:0] div_c, div_q;
  logic [31:0]        div_len;
  logic [1:0]         kidx;
  lavm_out_t          col_item;
  logic               out_load;

  assign kidx    = k_r[1:0];
  assign prod_x  = 68'(prod_r);
  assign acc_sum = acc_r + prod_x;
  assign len_ok  = (sq_root != '0) && (sq_root >= {2'b00, min_length});
  assign q_pop   = (state_r == ST_IDLE) && q_valid;
  assign out_load = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MAC: begin
        case (op_r)
          OP_VLEN: begin mul_a = pick3(view_r, kidx); mul_b = pick3(view_r, kidx); end
          OP_DOT:  begin mul_a = pick3(wup_r, kidx);  mul_b = pick3(view_r, kidx); end
          OP_ULEN: begin mul_a = pick3(up_r, kidx);   mul_b = pick3(up_r, kidx);   end
          OP_T0:   begin mul_a = pick3(eye_r, kidx);  mul_b = pick3(right_r, kidx); end
          OP_T1:   begin mul_a = pick3(eye_r, kidx);  mul_b = pick3(up_r, kidx);   end
          default: begin mul_a = pick3(eye_r, kidx);  mul_b = pick3(view_r, kidx); end
        endcase
      end
      ST_CAND: begin
        mul_a = pick3(view_r, kidx);
        mul_b = s_r;
      end
      ST_RIGHT: begin
        case (k_r)
          3'd0:    begin mul_a = up_r[1]; mul_b = view_r[2]; end
          3'd1:    begin mul_a = up_r[2]; mul_b = view_r[1]; end
          3'd2:    begin mul_a = up_r[2]; mul_b = view_r[0]; end
          3'd3:    begin mul_a = up_r[0]; mul_b = view_r[2]; end
          3'd4:    begin mul_a = up_r[0]; mul_b = view_r[1]; end
          default: begin mul_a = up_r[1]; mul_b = view_r[0]; end
        endcase
      end
      default: ;
    endcase
  end

  // Base vector of the current up candidate: world up, then Y, then Z.
  always_comb begin
    case (fb_r)
      2'd0:    base_c = pick3(wup_r, kidx - 2'd1);
      2'd1:    base_c = (kidx == 2'd2) ? ONE_DIR : '0;
      default: base_c = (kidx == 2'd3) ? ONE_DIR : '0;
    endcase
    cand_val = sat32(68'(base_c) - rnd(prod_x));
  end

  assign sq_start = (state_r == ST_MAC) && (k_r == 3'd3) &&
                    ((op_r == OP_VLEN) || (op_r == OP_ULEN));

  assign div_start = ((state_r == ST_SQRT) && sq_done && (op_r == OP_ULEN) && len_ok) ||
                     ((state_r == ST_DIV) && div_done && (cidx_r != 2'd2));
  assign div_c   = (state_r == ST_SQRT) ? up_r[0] : pick3(up_r, cidx_r + 2'd1);
  assign div_len = (state_r == ST_SQRT) ? sq_root : len_r;

  lavm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .rad   (acc_sum[63:0]),
    .done  (sq_done),
    .root  (sq_root)
  );

  lavm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .c     (div_c),
    .len   (div_len),
    .done  (div_done),
    .q     (div_q)
  );

  // Column currently due at the output.
  always_comb begin
    col_item.column_index = col_r;
    col_item.degenerate   = degen_r;
    col_item.is_last      = (col_r == 2'd3);
    if (degen_r) begin
      col_item.elem0 = (col_r == 2'd0) ? ONE_DIR : '0;
      col_item.elem1 = (col_r == 2'd1) ? ONE_DIR : '0;
      col_item.elem2 = (col_r == 2'd2) ? ONE_DIR : '0;
      col_item.elem3 = (col_r == 2'd3) ? Q16_ONE : '0;
    end else if (col_r != 2'd3) begin
      col_item.elem0 = pick3(right_r, col_r);
      col_item.elem1 = pick3(up_r, col_r);
      col_item.elem2 = pick3(view_r, col_r);
      col_item.elem3 = '0;
    end else begin
      col_item.elem0 = tr_r[0];
      col_item.elem1 = tr_r[1];
      col_item.elem2 = tr_r[2];
      col_item.elem3 = Q16_ONE;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_VLEN;
      k_r         <= '0;
      fb_r        <= '0;
      cidx_r      <= '0;
      col_r       <= '0;
      degen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            eye_r   <= {q_data.eye_z, q_data.eye_y, q_data.eye_x};
            view_r  <= {q_data.view_z, q_data.view_y, q_data.view_x};
            wup_r   <= {q_data.up_z, q_data.up_y, q_data.up_x};
            degen_r <= 1'b0;
            op_r    <= OP_VLEN;
            k_r     <= '0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd1) acc_r <= prod_x;
          else if (k_r == 3'd2) acc_r <= acc_sum;
          if (k_r == 3'd3) begin
            k_r <= '0;
            case (op_r) inside
              OP_VLEN, OP_ULEN: state_r <= ST_SQRT;
              OP_DOT: begin
                s_r     <= sat32(rnd(acc_sum));
                fb_r    <= '0;
                state_r <= ST_CAND;
              end
              OP_T0: begin
                tr_r[0] <= sat32(-rnd(acc_sum));
                op_r    <= OP_T1;
              end
              OP_T1: begin
                tr_r[1] <= sat32(-rnd(acc_sum));
                op_r    <= OP_T2;
              end
              default: begin
                tr_r[2] <= sat32(-rnd(acc_sum));
                col_r   <= '0;
                state_r <= ST_OUT;
              end
            endcase
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            if (op_r == OP_VLEN) begin
              if (len_ok) begin
                op_r    <= OP_DOT;
                state_r <= ST_MAC;
              end else begin
                degen_r <= 1'b1;
                col_r   <= '0;
                state_r <= ST_OUT;
              end
            end else if (len_ok) begin
              len_r   <= sq_root;
              cidx_r  <= '0;
              state_r <= ST_DIV;
            end else if (fb_r != 2'd2) begin
              fb_r    <= fb_r + 2'd1;
              s_r     <= (fb_r == 2'd0) ? view_r[1] : view_r[2];
              state_r <= ST_CAND;
            end else begin
              degen_r <= 1'b1;
              col_r   <= '0;
              state_r <= ST_OUT;
            end
          end
        end
        ST_CAND: begin
          k_r <= k_r + 3'd1;
          if (k_r != 3'd0) up_r[kidx - 2'd1] <= cand_val;
          if (k_r == 3'd3) begin
            k_r     <= '0;
            op_r    <= OP_ULEN;
            state_r <= ST_MAC;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            up_r[cidx_r] <= div_q;
            if (cidx_r == 2'd2) begin
              k_r     <= '0;
              state_r <= ST_RIGHT;
            end else begin
              cidx_r <= cidx_r + 2'd1;
            end
          end
        end
        ST_RIGHT: begin
          // Odd steps hold the first product of a pair; even steps subtract
          // the second and write one right component.
          k_r <= k_r + 3'd1;
          if (k_r[0]) acc_r <= prod_x;
          else if (k_r != 3'd0) right_r[k_r[2:1] - 2'd1] <= sat32(rnd(acc_r - prod_x));
          if (k_r == 3'd6) begin
            k_r     <= '0;
            op_r    <= OP_T0;
            state_r <= ST_MAC;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_r  <= col_item;
            out_valid_r <= 1'b1;
            col_r       <= col_r + 2'd1;
            if (col_r == 2'd3) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/look_at_view_matrix_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Builds a 4x4 look-at view matrix from eye, view and world-up and sends it
// as four column items.
// ----------------------------------------------------------------------------
// Usage:
// An input item (eye in Q16.16, view and up in Q2.30) is taken on in_valid
// while in_stall is low. A two-entry queue holds items while the back end
// works, so the sender sees a stall only when both entries are taken.
// Each item gives four output items, columns 0 to 3, is_last on column 3,
// presented with out_valid and held while out_stall is high; the back end
// may start the next item while the last column waits.
// The back end shares one multiplier and runs the square roots and the
// three normalizing divides one bit per cycle. Each up fallback that is tried
// adds another candidate and square root to an item, and an item whose view
// is too short skips the rest; the back end takes no new item from the queue
// until the last column of the one before is loaded into the output register.
// min_length is written through cfg_valid/cfg_ready (always ready); the
// user must write it only while the block is idle, which the block itself
// does not enforce. Reset empties the queue and the output register and
// sets min_length to 1074.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core import lavm_pkg::*; #(
  parameter int QUEUE_DEPTH = LAVM_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lavm_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lavm_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MIN_LEN_W-1:0] cfg_data
);

  logic [MIN_LEN_W-1:0] min_length_r;
  logic                 q_valid;
  lavm_in_t             q_data;
  logic                 q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MINLEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_length_r <= cfg_data;
    end
  end

  lavm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  lavm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .min_length (min_length_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== tb/look_at_view_matrix_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_core_test
// Drives eye, view and up items into the look-at core, predicts each of the
// four matrix columns in fixed point, and compares every column item field
// by field. Covers directed corner rows, several min_length settings,
// random unit-like and raw vectors, random idling and a long output stall.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core_test;
  import lavm_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int N_RANDOM = 360;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  lavm_in_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  lavm_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [MIN_LEN_W-1:0] cfg_data;

  logic [MIN_LEN_W-1:0] min_len_model;
  lavm_out_t            column_queue[$];
  int                   mismatches;
  int                   columns_seen;
  int                   items_sent;
  int                   degenerate_seen;
  bit                   hold_off;

  look_at_view_matrix_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------- predictor ----------------

  function automatic wide_t floor_div_pow(input wide_t x);
    return x >>> DIR_FRAC_BITS;
  endfunction

  function automatic wide_t clamp32(input wide_t x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  function automatic wide_t round_drop(input wide_t x);
    return floor_div_pow(x + (wide_t'(1) <<< (DIR_FRAC_BITS - 1)));
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Sum of squares wraps at 64 bits, as the datapath does.
  function automatic logic [63:0] vec_length(input wide_t v[3]);
    logic [63:0] s;
    s = 0;
    for (int i = 0; i < 3; i++) s = s + 64'(v[i] * v[i]);
    return int_sqrt(s);
  endfunction

  function automatic bit long_enough(input logic [63:0] len);
    return len != 0 && len >= 64'(min_len_model);
  endfunction

  function automatic wide_t dot_rounded(input wide_t a[3], input wide_t b[3]);
    return round_drop(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
  endfunction

  function automatic logic [63:0] make_candidate(input wide_t base[3], input wide_t dir[3],
                                                 input wide_t s, output wide_t c[3]);
    for (int i = 0; i < 3; i++) c[i] = clamp32(base[i] - round_drop(dir[i] * s));
    return vec_length(c);
  endfunction

  function automatic wide_t norm_div(input wide_t c, input logic [63:0] len);
    wide_t m;
    wide_t q;
    m = (c < 0) ? -c : c;
    q = ((m <<< DIR_FRAC_BITS) + wide_t'(len >> 1)) / wide_t'(len);
    return (c < 0) ? -q : q;
  endfunction

  task automatic predict_matrix(input lavm_in_t it);
    wide_t       eye[3], dir[3], wup[3], up[3], rgt[3], ybase[3], zbase[3];
    wide_t       m[4][4];
    logic [63:0] len;
    bit          degen;
    lavm_out_t   col;
    wide_t       one;
    one = wide_t'(1) <<< DIR_FRAC_BITS;
    eye = '{wide_t'(it.eye_x), wide_t'(it.eye_y), wide_t'(it.eye_z)};
    dir = '{wide_t'(it.view_x), wide_t'(it.view_y), wide_t'(it.view_z)};
    wup = '{wide_t'(it.up_x), wide_t'(it.up_y), wide_t'(it.up_z)};
    ybase = '{0, one, 0};
    zbase = '{0, 0, one};
    degen = 0;
    if (!long_enough(vec_length(dir))) begin
      degen = 1;
    end else begin
      len = make_candidate(wup, dir, clamp32(dot_rounded(wup, dir)), up);
      if (!long_enough(len)) begin
        len = make_candidate(ybase, dir, dir[1], up);
        if (!long_enough(len)) begin
          len = make_candidate(zbase, dir, dir[2], up);
          if (!long_enough(len)) degen = 1;
        end
      end
      if (!degen) begin
        for (int i = 0; i < 3; i++) up[i] = norm_div(up[i], len);
        rgt[0] = clamp32(round_drop(up[1] * dir[2] - up[2] * dir[1]));
        rgt[1] = clamp32(round_drop(up[2] * dir[0] - up[0] * dir[2]));
        rgt[2] = clamp32(round_drop(up[0] * dir[1] - up[1] * dir[0]));
      end
    end
    if (degen) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          m[c][i] = (c == i) ? ((c == 3) ? 65536 : one) : 0;
    end else begin
      for (int c = 0; c < 3; c++) begin
        m[c][0] = rgt[c];
        m[c][1] = up[c];
        m[c][2] = dir[c];
        m[c][3] = 0;
      end
      m[3][0] = clamp32(-dot_rounded(eye, rgt));
      m[3][1] = clamp32(-dot_rounded(eye, up));
      m[3][2] = clamp32(-dot_rounded(eye, dir));
      m[3][3] = 65536;
    end
    for (int c = 0; c < 4; c++) begin
      col.column_index = 2'(c);
      col.elem0        = m[c][0][31:0];
      col.elem1        = m[c][1][31:0];
      col.elem2        = m[c][2][31:0];
      col.elem3        = m[c][3][31:0];
      col.degenerate   = degen;
      col.is_last      = (c == 3);
      column_queue.push_back(col);
    end
  endtask

  // ---------------- checking ----------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH column %0d %s: got %h expected %h", columns_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lavm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (column_queue.size() == 0) begin
        report_mismatch("unexpected item", 32'(out_data.column_index), 0);
      end else begin
        want = column_queue.pop_front();
        if (out_data.column_index != want.column_index)
          report_mismatch("column_index", 32'(out_data.column_index), 32'(want.column_index));
        if (out_data.elem0 != want.elem0) report_mismatch("elem0", out_data.elem0, want.elem0);
        if (out_data.elem1 != want.elem1) report_mismatch("elem1", out_data.elem1, want.elem1);
        if (out_data.elem2 != want.elem2) report_mismatch("elem2", out_data.elem2, want.elem2);
        if (out_data.elem3 != want.elem3) report_mismatch("elem3", out_data.elem3, want.elem3);
        if (out_data.degenerate != want.degenerate)
          report_mismatch("degenerate", 32'(out_data.degenerate), 32'(want.degenerate));
        if (out_data.is_last != want.is_last)
          report_mismatch("is_last", 32'(out_data.is_last), 32'(want.is_last));
        if (want.degenerate && want.is_last) degenerate_seen++;
      end
      columns_seen++;
    end
  end

  // Receiver: random stall per item, plus a long hold-off on request.
  initial begin
    int gap;
    out_stall = 1'b1;
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------- stimulus ----------------

  function automatic logic [31:0] rand_dir_comp();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
      default: return 32'($signed($urandom_range(0, 32'h7fffffff)) - 32'sh40000000);
    endcase
  endfunction

  function automatic lavm_in_t random_item();
    lavm_in_t it;
    it.eye_x  = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
    it.eye_y  = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
    it.eye_z  = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
    it.view_x = rand_dir_comp();
    it.view_y = rand_dir_comp();
    it.view_z = rand_dir_comp();
    it.up_x   = rand_dir_comp();
    it.up_y   = rand_dir_comp();
    it.up_z   = rand_dir_comp();
    // Sometimes make up parallel to view to force the fallbacks.
    if ($urandom_range(0, 7) == 0) begin
      it.up_x = it.view_x;
      it.up_y = it.view_y;
      it.up_z = it.view_z;
    end
    if ($urandom_range(0, 15) == 0) begin
      it.view_x = $urandom_range(0, 3000);
      it.view_y = 0;
      it.view_z = 0;
    end
    return it;
  endfunction

  // Valid stays high from one item to the next when there is no idle gap.
  task automatic send_item(input lavm_in_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_matrix(it);
    items_sent++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (column_queue.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_min_length(input logic [MIN_LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    min_len_model = v;
    cfg_valid <= 1'b0;
  endtask

  typedef struct {
    lavm_in_t  stim;
    bit        known;
    logic      degen;
  } table_row_t;

  initial begin
    table_row_t rows[$];
    lavm_in_t   it;
    int         pos_one;
    int         neg;
    pos_one = 32'h40000000;
    neg     = 32'hc0000000;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    min_len_model = MINLEN_RESET;
    mismatches = 0;
    columns_seen = 0;
    items_sent = 0;
    degenerate_seen = 0;
    hold_off = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: zero view (identity), tiny view, canonical frames,
    // up parallel to view (Y then Z fallback), extreme fields.
    rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, pos_one, 0}, 1, 1'b1});
    rows.push_back('{'{5, 6, 7, 100, 0, 0, 0, pos_one, 0}, 1, 1'b1});
    rows.push_back('{'{0, 0, 0, 0, 0, pos_one, 0, pos_one, 0}, 0, 0});
    rows.push_back('{'{65536, -65536, 131072, 0, 0, neg, 0, pos_one, 0}, 0, 0});
    rows.push_back('{'{1, 2, 3, 0, pos_one, 0, 0, pos_one, 0}, 0, 0});
    rows.push_back('{'{1, 2, 3, 0, 0, pos_one, 0, 0, pos_one}, 0, 0});
    rows.push_back('{'{0, 0, 0, 0, pos_one, 0, 0, 0, 0}, 0, 0});
    rows.push_back('{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, pos_one, 0, 0, 0, pos_one, 0}, 0, 0});
    rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000, 0, 0, pos_one, pos_one, 0, 0}, 0, 0});
    rows.push_back('{'{32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h80000000}, 0, 0});
    rows.push_back('{'{32'h80000000, 32'h7fffffff, -1, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 0, 0});
    rows.push_back('{'{-1, -1, -1, -1, -1, -1, -1, -1, -1}, 0, 0});
    rows.push_back('{'{12345, 0, 0, 32'h2d413ccd, 0, 32'h2d413ccd, 0, pos_one, 0}, 0, 0});
    foreach (rows[r]) begin
      send_item(rows[r].stim);
      // Rows with a known answer are identity; cross-check the predictor too.
      if (rows[r].known && column_queue[column_queue.size() - 1].degenerate != rows[r].degen)
        report_mismatch("identity row predictor", 0, 32'(rows[r].degen));
    end
    drain_all();

    // Settings: zero threshold, maximum threshold, a random one, then back to the default.
    write_min_length('0);
    send_item('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_item('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    for (int i = 0; i < 20; i++) send_item(random_item());
    drain_all();
    write_min_length({MIN_LEN_W{1'b1}});
    send_item('{1, 1, 1, pos_one, 0, 0, 0, pos_one, 0});
    for (int i = 0; i < 20; i++) send_item(random_item());
    drain_all();
    write_min_length(MIN_LEN_W'($urandom_range(1, 2 ** 24)));
    for (int i = 0; i < 40; i++) send_item(random_item());
    drain_all();
    write_min_length(MINLEN_RESET);

    // Long receiver hold-off while the sender keeps offering items.
    hold_off = 1;
    for (int i = 0; i < N_RANDOM - 80; i++) begin
      it = random_item();
      send_item(it);
    end
    drain_all();

    $display("Sent %0d items, checked %0d columns, %0d degenerate matrices.",
             items_sent, columns_seen, degenerate_seen);
    $display("Thresholds covered: zero, maximum, random and reset default.");
    if (mismatches == 0) begin
      $display("look_at_view_matrix_core_test OK");
    end else begin
      $display("look_at_view_matrix_core_test NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout.");
    $display("look_at_view_matrix_core_test NOT OK");
    $finish;
  end

endmodule
